FILE: rtl/pia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pia_pkg;

  typedef enum logic [2:0] {
    KIND_READ    = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_CA1     = 3'd2,
    KIND_CA2     = 3'd3,
    KIND_CB1     = 3'd4,
    KIND_CB2     = 3'd5,
    KIND_TICK    = 3'd6,
    KIND_NOP     = 3'd7
  } kind_t;

  localparam logic [1:0] REG_ORA = 2'd0;
  localparam logic [1:0] REG_CRA = 2'd1;
  localparam logic [1:0] REG_ORB = 2'd2;
  localparam logic [1:0] REG_CRB = 2'd3;

  // Control register bit positions.
  localparam int CR_C1_IRQ_EN = 0;
  localparam int CR_C1_RISE   = 1;
  localparam int CR_PORT_SEL  = 2;
  localparam int CR_C2_BIT3   = 3;
  localparam int CR_C2_BIT4   = 4;
  localparam int CR_C2_OUT    = 5;
  localparam int CR_C2_FLAG   = 6;
  localparam int CR_C1_FLAG   = 7;

  // Cx2 control field values (bits 5..3).
  localparam logic [2:0] C2_HANDSHAKE = 3'b100;
  localparam logic [2:0] C2_PULSE     = 3'b101;

  // Line level bit positions.
  localparam int LINE_CA1 = 0;
  localparam int LINE_CA2 = 1;
  localparam int LINE_CB1 = 2;
  localparam int LINE_CB2 = 3;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] reg_offset;
    logic [7:0] value;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
  } request_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_drive;
    logic       port_a_strobe;
    logic [7:0] port_b_drive;
    logic       port_b_strobe;
    logic       ca2_level;
    logic       cb2_level;
    logic       irq_pulse;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/pia_core.sv
`timescale 1ns / 1ps
`default_nettype none

module pia_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire pia_pkg::request_t req,
  output pia_pkg::result_t       res
);

  logic [7:0] control_a, control_b, direction_a, direction_b, output_a, output_b;
  logic [3:0] line_levels;
  logic [1:0] pulse_pending;

  logic [7:0] control_a_next, control_b_next, direction_a_next, direction_b_next;
  logic [7:0] output_a_next, output_b_next;
  logic [3:0] line_levels_next;
  logic [1:0] pulse_pending_next;

  always_comb begin
    logic [7:0] ca, cb, da, db, oa, ob, rd, drv_a, drv_b, nv;
    logic [3:0] ll;
    logic [1:0] pp;
    logic       stb_a, stb_b, irq, lvl, old, hit;
    ca = control_a;
    cb = control_b;
    da = direction_a;
    db = direction_b;
    oa = output_a;
    ob = output_b;
    ll = line_levels;
    pp = pulse_pending;
    rd = '0;
    drv_a = '0;
    drv_b = '0;
    nv = '0;
    stb_a = 1'b0;
    stb_b = 1'b0;
    irq = 1'b0;
    lvl = req.value[0];
    old = 1'b0;
    hit = 1'b0;
    case (req.kind)
      pia_pkg::KIND_READ: begin
        case (req.reg_offset)
          pia_pkg::REG_ORA: begin
            if (ca[pia_pkg::CR_C2_OUT] && !ca[pia_pkg::CR_C2_BIT4]) begin
              ll[pia_pkg::LINE_CA2] = 1'b0;
              if (ca[pia_pkg::CR_C2_BIT3]) pp[0] = 1'b1;
            end
            rd = ca[pia_pkg::CR_PORT_SEL] ? req.port_a_pins : da;
          end
          pia_pkg::REG_CRA: rd = ca;
          pia_pkg::REG_ORB: rd = cb[pia_pkg::CR_PORT_SEL] ? req.port_b_pins : db;
          default: rd = cb;
        endcase
        if (!req.reg_offset[1]) begin
          ca[pia_pkg::CR_C1_FLAG] = 1'b0;
          ca[pia_pkg::CR_C2_FLAG] = 1'b0;
        end else begin
          cb[pia_pkg::CR_C1_FLAG] = 1'b0;
          cb[pia_pkg::CR_C2_FLAG] = 1'b0;
        end
      end
      pia_pkg::KIND_WRITE: begin
        case (req.reg_offset)
          pia_pkg::REG_ORA: begin
            if (ca[pia_pkg::CR_PORT_SEL]) begin
              drv_a = req.value & da;
              stb_a = 1'b1;
              oa = (oa & ~da) | drv_a;
            end else begin
              da = req.value;
            end
          end
          pia_pkg::REG_ORB: begin
            if (cb[pia_pkg::CR_C2_OUT] && !cb[pia_pkg::CR_C2_BIT4]) begin
              ll[pia_pkg::LINE_CB2] = 1'b0;
              if (cb[pia_pkg::CR_C2_BIT3]) pp[1] = 1'b1;
            end
            if (cb[pia_pkg::CR_PORT_SEL]) begin
              drv_b = req.value & db;
              stb_b = 1'b1;
              ob = (ob & ~db) | drv_b;
            end else begin
              db = req.value;
            end
          end
          pia_pkg::REG_CRA: begin
            nv = {ca[7:6], req.value[5:0]};
            ca = nv;
            if (nv[pia_pkg::CR_C2_OUT] && nv[pia_pkg::CR_C2_BIT4]) begin
              ll[pia_pkg::LINE_CA2] = nv[pia_pkg::CR_C2_BIT3];
            end
          end
          default: begin
            nv = {cb[7:6], req.value[5:0]};
            cb = nv;
            if (nv[pia_pkg::CR_C2_OUT] && nv[pia_pkg::CR_C2_BIT4]) begin
              ll[pia_pkg::LINE_CB2] = nv[pia_pkg::CR_C2_BIT3];
            end
          end
        endcase
      end
      pia_pkg::KIND_CA1: begin
        old = ll[pia_pkg::LINE_CA1];
        hit = ca[pia_pkg::CR_C1_RISE] ? (!old && lvl) : (old && !lvl);
        if (hit) begin
          ca[pia_pkg::CR_C1_FLAG] = 1'b1;
          irq = ca[pia_pkg::CR_C1_IRQ_EN];
          if (ca[5:3] == pia_pkg::C2_HANDSHAKE) ll[pia_pkg::LINE_CA2] = 1'b1;
        end
        ll[pia_pkg::LINE_CA1] = lvl;
      end
      pia_pkg::KIND_CA2: begin
        if (!ca[pia_pkg::CR_C2_OUT]) begin
          old = ll[pia_pkg::LINE_CA2];
          hit = ca[pia_pkg::CR_C2_BIT4] ? (!old && lvl) : (old && !lvl);
          if (hit) begin
            ca[pia_pkg::CR_C2_FLAG] = 1'b1;
            irq = ca[pia_pkg::CR_C2_BIT3];
          end
          ll[pia_pkg::LINE_CA2] = lvl;
        end
      end
      pia_pkg::KIND_CB1: begin
        old = ll[pia_pkg::LINE_CB1];
        hit = cb[pia_pkg::CR_C1_RISE] ? (!old && lvl) : (old && !lvl);
        if (hit) begin
          cb[pia_pkg::CR_C1_FLAG] = 1'b1;
          irq = cb[pia_pkg::CR_C1_IRQ_EN];
          if (cb[5:3] == pia_pkg::C2_HANDSHAKE) ll[pia_pkg::LINE_CB2] = 1'b1;
        end
        ll[pia_pkg::LINE_CB1] = lvl;
      end
      pia_pkg::KIND_CB2: begin
        if (!cb[pia_pkg::CR_C2_OUT]) begin
          old = ll[pia_pkg::LINE_CB2];
          hit = cb[pia_pkg::CR_C2_BIT4] ? (!old && lvl) : (old && !lvl);
          if (hit) begin
            cb[pia_pkg::CR_C2_FLAG] = 1'b1;
            irq = cb[pia_pkg::CR_C2_BIT3];
          end
          ll[pia_pkg::LINE_CB2] = lvl;
        end
      end
      pia_pkg::KIND_TICK: begin
        if (pp[0] && ca[5:3] == pia_pkg::C2_PULSE) ll[pia_pkg::LINE_CA2] = 1'b1;
        if (pp[1] && cb[5:3] == pia_pkg::C2_PULSE) ll[pia_pkg::LINE_CB2] = 1'b1;
        pp = 2'b00;
      end
      default: begin
      end
    endcase
    control_a_next = ca;
    control_b_next = cb;
    direction_a_next = da;
    direction_b_next = db;
    output_a_next = oa;
    output_b_next = ob;
    line_levels_next = ll;
    pulse_pending_next = pp;
    res.read_data = rd;
    res.port_a_drive = drv_a;
    res.port_a_strobe = stb_a;
    res.port_b_drive = drv_b;
    res.port_b_strobe = stb_b;
    res.ca2_level = ll[pia_pkg::LINE_CA2];
    res.cb2_level = ll[pia_pkg::LINE_CB2];
    res.irq_pulse = irq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_a <= '0;
      control_b <= '0;
      direction_a <= '0;
      direction_b <= '0;
      output_a <= '0;
      output_b <= '0;
      line_levels <= 4'hF;
      pulse_pending <= '0;
    end else if (fire) begin
      control_a <= control_a_next;
      control_b <= control_b_next;
      direction_a <= direction_a_next;
      direction_b <= direction_b_next;
      output_a <= output_a_next;
      output_b <= output_b_next;
      line_levels <= line_levels_next;
      pulse_pending <= pulse_pending_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/peripheral_interface_adapter.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-port parallel interface adapter in the 6520 register layout.
// Requests enter on the req channel (req_valid, req_stall): a bus read, a bus
// write, a new CA1/CA2/CB1/CB2 level, or a tick. Each request gives exactly one
// result on the rsp channel (rsp_valid, rsp_stall), in request order.
// A request is taken into an input register, evaluated combinationally against
// the control, direction, output and line state, and its result is registered
// in the output register, where rsp_valid marks it. One request is accepted
// every cycle while the receiver keeps rsp_stall low.
// When the receiver stalls, the result holds in the output register, the
// pending request waits in the input register, and req_stall rises only once
// both are full; the adapter state advances only as requests are evaluated.
// Reset empties both registers, clears all control, direction and output
// registers and the pulse marks, and sets the four control lines high.
module peripheral_interface_adapter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [2:0] kind,
  input  wire logic [1:0] reg_offset,
  input  wire logic [7:0] value,
  input  wire logic [7:0] port_a_pins,
  input  wire logic [7:0] port_b_pins,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic [7:0]      read_data,
  output logic [7:0]      port_a_drive,
  output logic            port_a_strobe,
  output logic [7:0]      port_b_drive,
  output logic            port_b_strobe,
  output logic            ca2_level,
  output logic            cb2_level,
  output logic            irq_pulse
);

  logic               req_full;
  pia_pkg::request_t  req_q;
  pia_pkg::result_t   res_d;
  pia_pkg::result_t   res_q;
  logic               advance;

  assign advance   = req_full && (!rsp_valid || !rsp_stall);
  assign req_stall = req_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        req_full <= 1'b1;
      end else if (advance) begin
        req_full <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q.kind <= pia_pkg::kind_t'(kind);
      req_q.reg_offset <= reg_offset;
      req_q.value <= value;
      req_q.port_a_pins <= port_a_pins;
      req_q.port_b_pins <= port_b_pins;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  pia_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .req  (req_q),
    .res  (res_d)
  );

  assign read_data     = res_q.read_data;
  assign port_a_drive  = res_q.port_a_drive;
  assign port_a_strobe = res_q.port_a_strobe;
  assign port_b_drive  = res_q.port_b_drive;
  assign port_b_strobe = res_q.port_b_strobe;
  assign ca2_level     = res_q.ca2_level;
  assign cb2_level     = res_q.cb2_level;
  assign irq_pulse     = res_q.irq_pulse;

endmodule

`default_nettype wire

FILE: tb/peripheral_interface_adapter_tb.sv
`timescale 1ns / 1ps

module peripheral_interface_adapter_tb;
  import pia_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MARK_CA2       = 0;
  localparam int MARK_CB2       = 1;

  logic       clk = 1'b0;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  logic [2:0] kind;
  logic [1:0] reg_offset;
  logic [7:0] value;
  logic [7:0] port_a_pins;
  logic [7:0] port_b_pins;
  logic       rsp_valid;
  logic       rsp_stall;
  logic [7:0] read_data;
  logic [7:0] port_a_drive;
  logic       port_a_strobe;
  logic [7:0] port_b_drive;
  logic       port_b_strobe;
  logic       ca2_level;
  logic       cb2_level;
  logic       irq_pulse;

  peripheral_interface_adapter dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .kind(kind),
    .reg_offset(reg_offset),
    .value(value),
    .port_a_pins(port_a_pins),
    .port_b_pins(port_b_pins),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .read_data(read_data),
    .port_a_drive(port_a_drive),
    .port_a_strobe(port_a_strobe),
    .port_b_drive(port_b_drive),
    .port_b_strobe(port_b_strobe),
    .ca2_level(ca2_level),
    .cb2_level(cb2_level),
    .irq_pulse(irq_pulse)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the adapter state.
  logic [7:0] ctl_a = '0;
  logic [7:0] ctl_b = '0;
  logic [7:0] ddr_a = '0;
  logic [7:0] ddr_b = '0;
  logic [7:0] out_a = '0;
  logic [7:0] out_b = '0;
  logic [3:0] lines = 4'hF;
  logic [1:0] pulse_marks = '0;

  request_t request_backlog[$];
  result_t  pending_results[$];
  int       reqs_queued = 0;
  int       reqs_taken = 0;
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       idle_cycles = 0;
  bit       req_taken = 1'b0;

  function automatic void c2_strobe(input logic [7:0] ctl, input int c2, input int mark);
    if (ctl[CR_C2_OUT] && !ctl[CR_C2_BIT4]) begin
      lines[c2] = 1'b0;
      if (ctl[CR_C2_BIT3]) pulse_marks[mark] = 1'b1;
    end
  endfunction

  function automatic logic c1_edge(input logic [7:0] ctl, input int c1, input int c2,
                                   input logic lvl, output logic [7:0] ctl_next);
    logic hit;
    logic irq;
    irq = 1'b0;
    ctl_next = ctl;
    hit = ctl[CR_C1_RISE] ? (!lines[c1] && lvl) : (lines[c1] && !lvl);
    if (hit) begin
      ctl_next[CR_C1_FLAG] = 1'b1;
      irq = ctl[CR_C1_IRQ_EN];
      if (ctl[CR_C2_OUT:CR_C2_BIT3] == C2_HANDSHAKE) lines[c2] = 1'b1;
    end
    lines[c1] = lvl;
    return irq;
  endfunction

  function automatic logic c2_edge(input logic [7:0] ctl, input int c2, input logic lvl,
                                   output logic [7:0] ctl_next);
    logic hit;
    logic irq;
    irq = 1'b0;
    ctl_next = ctl;
    if (!ctl[CR_C2_OUT]) begin
      hit = ctl[CR_C2_BIT4] ? (!lines[c2] && lvl) : (lines[c2] && !lvl);
      if (hit) begin
        ctl_next[CR_C2_FLAG] = 1'b1;
        irq = ctl[CR_C2_BIT3];
      end
      lines[c2] = lvl;
    end
    return irq;
  endfunction

  function automatic result_t adapter_step(request_t r);
    result_t    res;
    logic [7:0] nv;
    res = '0;
    case (r.kind)
      KIND_READ: begin
        case (r.reg_offset)
          REG_ORA: begin
            c2_strobe(ctl_a, LINE_CA2, MARK_CA2);
            res.read_data = ctl_a[CR_PORT_SEL] ? r.port_a_pins : ddr_a;
          end
          REG_CRA: res.read_data = ctl_a;
          REG_ORB: res.read_data = ctl_b[CR_PORT_SEL] ? r.port_b_pins : ddr_b;
          default: res.read_data = ctl_b;
        endcase
        if (r.reg_offset == REG_ORA || r.reg_offset == REG_CRA) begin
          ctl_a[CR_C1_FLAG] = 1'b0;
          ctl_a[CR_C2_FLAG] = 1'b0;
        end else begin
          ctl_b[CR_C1_FLAG] = 1'b0;
          ctl_b[CR_C2_FLAG] = 1'b0;
        end
      end
      KIND_WRITE: begin
        case (r.reg_offset)
          REG_ORA: begin
            if (ctl_a[CR_PORT_SEL]) begin
              res.port_a_drive = r.value & ddr_a;
              res.port_a_strobe = 1'b1;
              out_a = (out_a & ~ddr_a) | res.port_a_drive;
            end else begin
              ddr_a = r.value;
            end
          end
          REG_ORB: begin
            c2_strobe(ctl_b, LINE_CB2, MARK_CB2);
            if (ctl_b[CR_PORT_SEL]) begin
              res.port_b_drive = r.value & ddr_b;
              res.port_b_strobe = 1'b1;
              out_b = (out_b & ~ddr_b) | res.port_b_drive;
            end else begin
              ddr_b = r.value;
            end
          end
          REG_CRA: begin
            ctl_a = {ctl_a[CR_C1_FLAG:CR_C2_FLAG], r.value[CR_C2_OUT:0]};
            if (ctl_a[CR_C2_OUT] && ctl_a[CR_C2_BIT4]) lines[LINE_CA2] = ctl_a[CR_C2_BIT3];
          end
          default: begin
            ctl_b = {ctl_b[CR_C1_FLAG:CR_C2_FLAG], r.value[CR_C2_OUT:0]};
            if (ctl_b[CR_C2_OUT] && ctl_b[CR_C2_BIT4]) lines[LINE_CB2] = ctl_b[CR_C2_BIT3];
          end
        endcase
      end
      KIND_CA1: begin
        res.irq_pulse = c1_edge(ctl_a, LINE_CA1, LINE_CA2, r.value[0], nv);
        ctl_a = nv;
      end
      KIND_CA2: begin
        res.irq_pulse = c2_edge(ctl_a, LINE_CA2, r.value[0], nv);
        ctl_a = nv;
      end
      KIND_CB1: begin
        res.irq_pulse = c1_edge(ctl_b, LINE_CB1, LINE_CB2, r.value[0], nv);
        ctl_b = nv;
      end
      KIND_CB2: begin
        res.irq_pulse = c2_edge(ctl_b, LINE_CB2, r.value[0], nv);
        ctl_b = nv;
      end
      KIND_TICK: begin
        if (pulse_marks[MARK_CA2] && ctl_a[CR_C2_OUT:CR_C2_BIT3] == C2_PULSE)
          lines[LINE_CA2] = 1'b1;
        if (pulse_marks[MARK_CB2] && ctl_b[CR_C2_OUT:CR_C2_BIT3] == C2_PULSE)
          lines[LINE_CB2] = 1'b1;
        pulse_marks = '0;
      end
      default: ;
    endcase
    res.ca2_level = lines[LINE_CA2];
    res.cb2_level = lines[LINE_CB2];
    return res;
  endfunction

  function automatic string fmt_result(result_t r);
    return $sformatf("rd=%h a_drv=%h a_stb=%b b_drv=%h b_stb=%b ca2=%b cb2=%b irq=%b",
                     r.read_data, r.port_a_drive, r.port_a_strobe, r.port_b_drive,
                     r.port_b_strobe, r.ca2_level, r.cb2_level, r.irq_pulse);
  endfunction

  task automatic push_req(input kind_t k, input logic [1:0] off, input logic [7:0] v,
                          input logic [7:0] pa, input logic [7:0] pb);
    request_t r;
    r.kind = k;
    r.reg_offset = off;
    r.value = v;
    r.port_a_pins = pa;
    r.port_b_pins = pb;
    request_backlog.push_back(r);
    reqs_queued++;
  endtask

  task automatic push_noise();
    push_req(kind_t'($urandom_range(7)), 2'($urandom_range(3)), 8'($urandom),
             8'($urandom), 8'($urandom));
  endtask

  // A control write on one port followed by a run of accesses and line events,
  // mostly on the same port, with ticks and random requests mixed in.
  task automatic push_port_burst();
    bit         port_b;
    logic [1:0] cr;
    logic [1:0] orr;
    kind_t      c1;
    kind_t      c2;
    int         n;
    port_b = 1'($urandom_range(1));
    cr  = port_b ? REG_CRB : REG_CRA;
    orr = port_b ? REG_ORB : REG_ORA;
    c1  = port_b ? KIND_CB1 : KIND_CA1;
    c2  = port_b ? KIND_CB2 : KIND_CA2;
    push_req(KIND_WRITE, cr, 8'($urandom), 8'($urandom), 8'($urandom));
    n = $urandom_range(3, 10);
    repeat (n) begin
      case ($urandom_range(9))
        0: push_req(KIND_READ, orr, 8'($urandom), 8'($urandom), 8'($urandom));
        1: push_req(KIND_WRITE, orr, 8'($urandom), 8'($urandom), 8'($urandom));
        2, 3: push_req(c1, 2'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom));
        4: push_req(c2, 2'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom));
        5: push_req(KIND_TICK, 2'($urandom_range(3)), 8'($urandom), 8'($urandom),
                    8'($urandom));
        6: push_req(KIND_READ, cr, 8'($urandom), 8'($urandom), 8'($urandom));
        7: push_req(KIND_WRITE, cr, 8'($urandom), 8'($urandom), 8'($urandom));
        default: push_noise();
      endcase
    end
  endtask

  task automatic push_random(input int count);
    int stop_at;
    stop_at = reqs_queued + count;
    while (reqs_queued < stop_at) begin
      if ($urandom_range(9) < 8) push_port_burst();
      else push_noise();
    end
  endtask

  task automatic wait_drained();
    while (!(reqs_taken == reqs_queued && pending_results.size() == 0)) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_taken) begin
      req_valid <= 1'b1;
    end else if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      request_t r;
      r = request_backlog.pop_front();
      kind <= r.kind;
      reg_offset <= r.reg_offset;
      value <= r.value;
      port_a_pins <= r.port_a_pins;
      port_b_pins <= r.port_b_pins;
      req_valid <= 1'b1;
    end else begin
      req_valid <= 1'b0;
    end
    rsp_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        got = {read_data, port_a_drive, port_a_strobe, port_b_drive, port_b_strobe,
               ca2_level, cb2_level, irq_pulse};
        if (pending_results.size() == 0) begin
          if (mismatches < 10) $display("%0t: unexpected result: %s", $time, fmt_result(got));
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
            mismatches++;
          end
        end
      end
      req_taken = req_valid && !req_stall;
      if (req_taken) begin
        pending_results.push_back(adapter_step(request_t'({kind, reg_offset, value,
                                                           port_a_pins, port_b_pins})));
        reqs_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("peripheral_interface_adapter_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    rsp_stall = 1'b0;
    kind = KIND_NOP;
    reg_offset = REG_ORA;
    value = '0;
    port_a_pins = '0;
    port_b_pins = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_req(KIND_READ,  REG_CRA, 8'h00, 8'h00, 8'h00);
    push_req(KIND_READ,  REG_ORA, 8'hFF, 8'hFF, 8'hFF);
    push_req(KIND_WRITE, REG_ORA, 8'hFF, 8'h00, 8'h00);
    push_req(KIND_WRITE, REG_CRA, 8'h04, 8'h00, 8'h00);
    push_req(KIND_WRITE, REG_ORA, 8'hA5, 8'h00, 8'h00);
    push_req(KIND_READ,  REG_ORA, 8'h00, 8'hFF, 8'h00);
    push_req(KIND_READ,  REG_ORA, 8'h00, 8'h00, 8'hFF);
    push_req(KIND_WRITE, REG_CRA, 8'h05, 8'h00, 8'h00);
    push_req(KIND_CA1,   REG_ORA, 8'h00, 8'h00, 8'h00);
    push_req(KIND_READ,  REG_CRA, 8'h00, 8'h00, 8'h00);
    push_req(KIND_WRITE, REG_CRA, 8'h07, 8'h00, 8'h00);
    push_req(KIND_CA1,   REG_ORA, 8'hFF, 8'h00, 8'h00);
    push_req(KIND_WRITE, REG_CRA, 8'h0C, 8'h00, 8'h00);
    push_req(KIND_CA2,   REG_ORA, 8'hFE, 8'h00, 8'h00);
    push_req(KIND_READ,  REG_ORA, 8'h00, 8'h5A, 8'h00);
    push_req(KIND_WRITE, REG_CRA, 8'h24, 8'h00, 8'h00);
    push_req(KIND_READ,  REG_ORA, 8'h00, 8'h00, 8'h00);
    push_req(KIND_CA1,   REG_ORA, 8'h00, 8'h00, 8'h00);
    push_req(KIND_WRITE, REG_CRA, 8'h2C, 8'h00, 8'h00);
    push_req(KIND_READ,  REG_ORA, 8'h00, 8'h00, 8'h00);
    push_req(KIND_CA2,   REG_ORA, 8'h01, 8'h00, 8'h00);
    push_req(KIND_TICK,  REG_ORA, 8'h00, 8'h00, 8'h00);
    push_req(KIND_WRITE, REG_CRA, 8'h38, 8'h00, 8'h00);
    push_req(KIND_WRITE, REG_CRA, 8'h30, 8'h00, 8'h00);
    push_req(KIND_WRITE, REG_CRB, 8'hFF, 8'h00, 8'h00);
    push_req(KIND_WRITE, REG_CRB, 8'h2C, 8'h00, 8'h00);
    push_req(KIND_WRITE, REG_ORB, 8'h3C, 8'h00, 8'h00);
    push_req(KIND_CB1,   REG_CRB, 8'h00, 8'h00, 8'h00);
    push_req(KIND_TICK,  REG_CRB, 8'h00, 8'h00, 8'h00);
    push_req(KIND_WRITE, REG_CRB, 8'h08, 8'h00, 8'h00);
    push_req(KIND_CB2,   REG_CRB, 8'h00, 8'h00, 8'h00);
    push_req(KIND_READ,  REG_CRB, 8'h00, 8'h00, 8'h00);
    push_req(KIND_NOP,   REG_CRB, 8'hFF, 8'hFF, 8'hFF);
    push_random(380);
    wait_drained();

    @(posedge clk);
    send_idle_pct = 79;
    stall_pct = 0;
    push_random(380);
    wait_drained();

    @(posedge clk);
    send_idle_pct = 0;
    stall_pct = 79;
    push_random(380);
    wait_drained();

    @(posedge clk);
    send_idle_pct = 11;
    stall_pct = 11;
    push_random(380);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("peripheral_interface_adapter_tb: PASS");
    end else begin
      $display("peripheral_interface_adapter_tb: FAIL");
    end
    $finish;
  end

endmodule
